FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/mio0_pkg.sv
// ----------------------------------------------------------------------------
// mio0_pkg
// Token codes, constants and the result word type of the MIO0 decoder.
// ----------------------------------------------------------------------------
package mio0_pkg;

  // Token kinds on in_req_type.
  localparam logic [1:0] REQ_FLAG = 2'd0;
  localparam logic [1:0] REQ_LIT  = 2'd1;
  localparam logic [1:0] REQ_REF  = 2'd2;

  localparam int unsigned FLAG_COUNT   = 32;
  localparam int unsigned REF_LEN_BIAS = 3;
  localparam int unsigned DIST_BITS    = 12;

  // One result word as it leaves the decoder.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
    logic       token_error;
  } result_t;

endpackage

FILE: rtl/mio0_hist_ram.sv
// ----------------------------------------------------------------------------
// mio0_hist_ram
// History window: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module mio0_hist_ram #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/mio0_out_stage.sv
// ----------------------------------------------------------------------------
// mio0_out_stage
// Output register of the result channel with valid and stall.
// ----------------------------------------------------------------------------
module mio0_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mio0_pkg::result_t load_res,
  output logic              free,
  input  logic              out_stall,
  output logic              out_valid,
  output mio0_pkg::result_t out_res
);

  logic              valid_r;
  mio0_pkg::result_t res_r;

  // The register can take a new word when empty or when its word leaves now.
  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/mio0_lz_decoder.sv
// ----------------------------------------------------------------------------
// mio0_lz_decoder
// MIO0-style LZ decoder fed one token (flag word, literal or back reference)
// at a time, producing one output word per decoded byte or rejected token.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  req_type, flag_word, literal_value,
//                                          reference_code
//   out      output     out_valid/out_stall out_byte, last_of_run,
//                                          stream_done, token_error
//   cfg      input      cfg_wr_en          cfg_wr_data (output_size)
//
// A flag word, a literal or an error token is handled when it is accepted. A back
// reference of length L (3 to 18) issues the first history read when accepted, then
// copies one byte per cycle unless stalled, each write paired with the next read.
// Reset is synchronous and active low. A write position plus a wrap flag makes
// never-written history entries read as zero, so no clearing pass is needed.
// An output stall freezes the copy; the input is stalled during a copy and
// while the output register is full and stalled.
module mio0_lz_decoder #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // Token input.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_flag_word,
  input  logic [7:0]  in_literal_value,
  input  logic [15:0] in_reference_code,
  // Decoded output.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_stream_done,
  output logic        out_token_error
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned DW = mio0_pkg::DIST_BITS + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_COPY = 1'b1;

  // Sequencer and decoder state.
  logic        state_r, state_nxt;
  logic [31:0] output_size_r;
  logic [31:0] bytes_emitted_r, bytes_emitted_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic        wrapped_r, wrapped_nxt;
  logic [31:0] pending_flags_r, pending_flags_nxt;
  logic [5:0]  flags_left_r, flags_left_nxt;
  logic [4:0]  remain_r, remain_nxt;
  logic [mio0_pkg::DIST_BITS-1:0] dist_m1_r, dist_m1_nxt;
  logic        first_r, first_nxt;
  logic        rd_valid_r, rd_valid_nxt;

  // Memory and output stage connections.
  logic        mem_we;
  logic [7:0]  mem_wdata;
  logic        mem_re;
  logic [7:0]  mem_rdata;
  logic        out_load;
  logic        out_free;
  mio0_pkg::result_t out_load_res;
  mio0_pkg::result_t out_res;

  // Shared address unit inputs and outputs.
  logic [AW-1:0] addr_base;
  logic          addr_base_wrapped;
  logic [mio0_pkg::DIST_BITS-1:0] addr_dist_m1;
  logic [AW:0]   ra_sum;
  logic [AW-1:0] ra;
  logic          ra_valid;

  logic        accept;
  logic        done;
  logic [1:0]  expected;
  logic        kind_ok;
  logic [31:0] cnt_inc;
  logic        done_after;
  logic [AW-1:0] wp_inc;
  logic        wp_at_end;
  logic [7:0]  copy_byte;
  logic        copy_last;

  assign done      = bytes_emitted_r >= output_size_r;
  assign cnt_inc   = bytes_emitted_r + 32'd1;
  assign done_after = cnt_inc >= output_size_r;
  assign wp_at_end = wp_r == AW'(WINDOW_DEPTH - 1);
  assign wp_inc    = wp_at_end ? '0 : wp_r + 1'b1;

  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (flags_left_r == 6'd0) begin
      expected = mio0_pkg::REQ_FLAG;
    end else if (pending_flags_r[31]) begin
      expected = mio0_pkg::REQ_LIT;
    end else begin
      expected = mio0_pkg::REQ_REF;
    end
  end
  assign kind_ok = !done && (in_req_type == expected);

  // Read address: base minus distance, modulo the window depth. An entry is
  // valid once written, which for a window that has not wrapped means it
  // lies below the write position.
  always_comb begin
    ra_sum = {1'b0, addr_base} + (AW + 1)'(WINDOW_DEPTH)
             - (AW + 1)'({1'b0, addr_dist_m1} + DW'(1));
    if (ra_sum >= (AW + 1)'(WINDOW_DEPTH)) begin
      ra = ra_sum[AW-1:0] - AW'(WINDOW_DEPTH);
    end else begin
      ra = ra_sum[AW-1:0];
    end
    ra_valid = addr_base_wrapped || (ra < addr_base);
  end

  // With a distance of one, every byte after the first repeats the byte
  // that was just emitted, which the RAM cannot return yet.
  assign copy_byte = ((dist_m1_r == '0) && !first_r) ? out_res.out_byte :
                     (rd_valid_r ? mem_rdata : 8'd0);
  assign copy_last = (remain_r == 5'd1) || done_after;

  always_comb begin
    state_nxt         = state_r;
    bytes_emitted_nxt = bytes_emitted_r;
    wp_nxt            = wp_r;
    wrapped_nxt       = wrapped_r;
    pending_flags_nxt = pending_flags_r;
    flags_left_nxt    = flags_left_r;
    remain_nxt        = remain_r;
    dist_m1_nxt       = dist_m1_r;
    first_nxt         = first_r;
    rd_valid_nxt      = rd_valid_r;
    mem_we            = 1'b0;
    mem_wdata         = in_literal_value;
    mem_re            = 1'b0;
    out_load          = 1'b0;
    out_load_res      = '{out_byte: 8'd0, last_of_run: 1'b1,
                          stream_done: done, token_error: 1'b1};
    addr_base         = wp_r;
    addr_base_wrapped = wrapped_r;
    addr_dist_m1      = in_reference_code[mio0_pkg::DIST_BITS-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!kind_ok) begin
            out_load = 1'b1;
          end else begin
            unique case (in_req_type)
              mio0_pkg::REQ_FLAG: begin
                pending_flags_nxt = in_flag_word;
                flags_left_nxt    = 6'(mio0_pkg::FLAG_COUNT);
              end
              mio0_pkg::REQ_LIT: begin
                mem_we            = 1'b1;
                wp_nxt            = wp_inc;
                wrapped_nxt       = wrapped_r || wp_at_end;
                bytes_emitted_nxt = cnt_inc;
                pending_flags_nxt = pending_flags_r << 1;
                flags_left_nxt    = flags_left_r - 6'd1;
                out_load          = 1'b1;
                out_load_res      = '{out_byte: in_literal_value, last_of_run: 1'b1,
                                      stream_done: done_after, token_error: 1'b0};
              end
              default: begin
                // Back reference: issue the first history read now.
                mem_re       = 1'b1;
                rd_valid_nxt = ra_valid;
                remain_nxt   = 5'(in_reference_code[15:12]) + 5'(mio0_pkg::REF_LEN_BIAS);
                dist_m1_nxt  = in_reference_code[mio0_pkg::DIST_BITS-1:0];
                first_nxt    = 1'b1;
                state_nxt    = S_COPY;
              end
            endcase
          end
        end
      end
      default: begin
        addr_base         = wp_inc;
        addr_base_wrapped = wrapped_r || wp_at_end;
        addr_dist_m1      = dist_m1_r;
        if (out_free) begin
          mem_we            = 1'b1;
          mem_wdata         = copy_byte;
          wp_nxt            = wp_inc;
          wrapped_nxt       = wrapped_r || wp_at_end;
          bytes_emitted_nxt = cnt_inc;
          remain_nxt        = remain_r - 5'd1;
          first_nxt         = 1'b0;
          out_load          = 1'b1;
          out_load_res      = '{out_byte: copy_byte, last_of_run: copy_last,
                                stream_done: done_after, token_error: 1'b0};
          if (copy_last) begin
            pending_flags_nxt = pending_flags_r << 1;
            flags_left_nxt    = flags_left_r - 6'd1;
            state_nxt         = S_IDLE;
          end else begin
            mem_re       = 1'b1;
            rd_valid_nxt = ra_valid;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      output_size_r   <= 32'd0;
      bytes_emitted_r <= 32'd0;
      wp_r            <= '0;
      wrapped_r       <= 1'b0;
      pending_flags_r <= 32'd0;
      flags_left_r    <= 6'd0;
      remain_r        <= 5'd0;
      first_r         <= 1'b0;
      rd_valid_r      <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      bytes_emitted_r <= bytes_emitted_nxt;
      wp_r            <= wp_nxt;
      wrapped_r       <= wrapped_nxt;
      pending_flags_r <= pending_flags_nxt;
      flags_left_r    <= flags_left_nxt;
      remain_r        <= remain_nxt;
      first_r         <= first_nxt;
      rd_valid_r      <= rd_valid_nxt;
      if (cfg_wr_en) begin
        output_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_m1_r <= dist_m1_nxt;
  end

  mio0_hist_ram #(
    .DEPTH(WINDOW_DEPTH)
  ) u_hist_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(wp_r),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(ra),
    .rd_data(mem_rdata)
  );

  mio0_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .load_res (out_load_res),
    .free     (out_free),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  assign out_byte        = out_res.out_byte;
  assign out_last_of_run = out_res.last_of_run;
  assign out_stream_done = out_res.stream_done;
  assign out_token_error = out_res.token_error;

endmodule

FILE: rtl/mio0_lz_checker.sv
// ----------------------------------------------------------------------------
// mio0_lz_checker
// Port-level checks on the MIO0 decoder, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mio0_lz_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_last_of_run,
  input logic        out_stream_done,
  input logic        out_token_error
);

  // An error word carries a zero byte and closes its token.
  `ASSERT_RST(a_err_word, clk, rst_n, out_valid && out_token_error |-> out_byte == 8'd0 && out_last_of_run, "error word must have zero byte and last set")

  // Reaching the output size ends the current token.
  `ASSERT_RST(a_done_is_last, clk, rst_n, out_valid && out_stream_done |-> out_last_of_run, "stream done word must be last of its token")

  // A stalled word stays put.
  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_of_run), "stalled output word changed")

  // Nothing leaves the block in the cycle after reset.
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind mio0_lz_decoder mio0_lz_checker u_mio0_lz_checker (.*);
